// ===== hdl/hash_map_get_or_create_linear_probe_defines.svh =====
// Assertion macros for the checker file of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HASH_MAP_GET_OR_CREATE_LINEAR_PROBE_DEFINES_SVH
`define HASH_MAP_GET_OR_CREATE_LINEAR_PROBE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HMGOC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HMGOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hmgoc_pkg.sv =====
package hmgoc_pkg;

    // Number of slots in the table.
    localparam int unsigned POOL_SIZE = 128;
    localparam int unsigned IDX_W     = $clog2(POOL_SIZE);

    // Fixed field widths of the request and response.
    localparam int unsigned KEY_W  = 32;
    localparam int unsigned SLOT_W = 7;

    localparam logic [KEY_W-1:0] HASH_MULT   = 32'd2654435761;
    localparam logic [KEY_W-1:0] POOL_SIZE_W = KEY_W'(POOL_SIZE);

    localparam logic ACT_GET_OR_CREATE = 1'b0;
    localparam logic ACT_SET_BUSY      = 1'b1;

    typedef logic [IDX_W-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_CREATED  = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_BUSY_SET = 2'd3
    } status_t;

    // Linear probing step with wrap at the end of the table.
    function automatic slot_idx_t next_slot(input slot_idx_t i);
        slot_idx_t r;
        if (i == IDX_W'(POOL_SIZE - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== hdl/hmgoc_req_if.sv =====
interface hmgoc_req_if import hmgoc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot_index;
    logic              busy_flag;

    modport source (
        output valid, action, key, slot_index, busy_flag,
        input  ready
    );

    modport sink (
        input  valid, action, key, slot_index, busy_flag,
        output ready
    );
endinterface

// ===== hdl/hmgoc_rsp_if.sv =====
interface hmgoc_rsp_if import hmgoc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] result_slot;
    logic [1:0]        status;

    modport source (
        output valid, result_slot, status,
        input  ready
    );

    modport sink (
        input  valid, result_slot, status,
        output ready
    );
endinterface

// ===== hdl/hash_map_get_or_create_linear_probe.sv =====
// Get-or-create hash table with linear probing and per-slot busy marks.
// Requests arrive on req (valid/ready); each request yields exactly one
// response on rsp (valid/ready), in request order.
// Action get-or-create hashes the key, probes for a matching key, and on a
// miss probes again for the first slot that is not busy and stores the key.
// Action set-busy writes the busy mark of one slot.
// Set-busy steps through S_BUSY_RD, S_BUSY_WR and S_RESP. Get-or-create
// steps through S_HASH, S_START and S_LOOKUP, then S_CREATE_INIT and
// S_CREATE when the lookup misses, then S_RESP; lookup and create each
// visit up to POOL_SIZE slots. One table read port is shared by both probe
// passes and delivers one slot per cycle.
// The block takes one request at a time; req.ready is high only when idle.
// The response sits in an output register, so a new request can be taken
// while the previous response still waits; a stalled rsp holds its payload,
// and a finished request waits there until the register frees up.
// Reset clears every key and busy mark at once through per-slot valid bits;
// no clearing pass is needed, and the block is ready right after reset.
module hash_map_get_or_create_linear_probe
    import hmgoc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    hmgoc_req_if.sink  req,
    hmgoc_rsp_if.source rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_START,
        S_LOOKUP,
        S_CREATE_INIT,
        S_CREATE,
        S_BUSY_RD,
        S_BUSY_WR,
        S_RESP
    } state_t;

    state_t             state_reg, state_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [SLOT_W-1:0]  sidx_reg, sidx_next;
    logic               bflag_reg, bflag_next;
    logic [KEY_W-1:0]   prod_reg, prod_next;
    slot_idx_t          start_reg, start_next;
    slot_idx_t          probe_reg, probe_next;
    slot_idx_t          cur_reg, cur_next;
    logic               pend_reg, pend_next;
    logic               first_reg, first_next;
    logic               issued_all_reg, issued_all_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    status_t            res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    status_t            out_status_reg, out_status_next;

    // Table storage: each word holds the busy mark above the key.
    logic [KEY_W:0]     mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] vld_reg;
    logic [KEY_W:0]     rd_word_reg;
    logic               rd_vld_reg;

    slot_idx_t          rd_addr;
    logic               mem_we;
    slot_idx_t          mem_wa;
    logic [KEY_W:0]     mem_wd;
    logic [KEY_W-1:0]   key_q;
    logic               busy_q;
    logic               lk_hit;
    logic               lk_miss;
    logic               sidx_in_range;
    logic               load_out;

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_slot = out_slot_reg;
    assign rsp.status      = out_status_reg;

    // A slot never written since reset reads as key zero, not busy.
    assign key_q  = rd_vld_reg ? rd_word_reg[KEY_W-1:0] : '0;
    assign busy_q = rd_vld_reg ? rd_word_reg[KEY_W] : 1'b0;

    // The hash slot is compared even when it holds zero; any later slot
    // holding zero ends the lookup before it is compared.
    assign lk_hit  = (key_q == key_reg) && (first_reg || (key_q != '0));
    assign lk_miss = !lk_hit
                     && ((!first_reg && (key_q == '0)) || (next_slot(cur_reg) == start_reg));

    assign sidx_in_range = (KEY_W'(sidx_reg) < POOL_SIZE_W);
    assign load_out      = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        rd_addr = probe_reg;
        if (state_reg == S_BUSY_RD)
        begin
            rd_addr = IDX_W'(sidx_reg);
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cur_reg;
        mem_wd = {1'b0, key_reg};
        if ((state_reg == S_CREATE) && pend_reg && !busy_q)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_BUSY_WR)
        begin
            mem_we = 1'b1;
            mem_wa = IDX_W'(sidx_reg);
            mem_wd = {bflag_reg, key_q};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[mem_wa] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        sidx_next       = sidx_reg;
        bflag_next      = bflag_reg;
        prod_next       = prod_reg;
        start_next      = start_reg;
        probe_next      = probe_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        first_next      = first_reg;
        issued_all_next = issued_all_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next    = req.key;
                    sidx_next   = req.slot_index;
                    bflag_next  = req.busy_flag;
                    if (req.action == ACT_SET_BUSY)
                    begin
                        state_next = S_BUSY_RD;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                prod_next  = key_reg * HASH_MULT;
                state_next = S_START;
            end
            S_START:
            begin
                start_next      = IDX_W'(prod_reg % POOL_SIZE_W);
                probe_next      = IDX_W'(prod_reg % POOL_SIZE_W);
                pend_next       = 1'b0;
                issued_all_next = 1'b0;
                state_next      = S_LOOKUP;
            end
            S_LOOKUP, S_CREATE:
            begin
                // Reads stream one slot per cycle; the data of the slot read
                // last cycle is judged while the next read goes out.
                pend_next  = !issued_all_reg;
                cur_next   = probe_reg;
                first_next = (probe_reg == start_reg);
                if (!issued_all_reg)
                begin
                    probe_next      = next_slot(probe_reg);
                    issued_all_next = (next_slot(probe_reg) == start_reg);
                end
                if (pend_reg)
                begin
                    if (state_reg == S_LOOKUP)
                    begin
                        if (lk_hit)
                        begin
                            res_slot_next   = SLOT_W'(cur_reg);
                            res_status_next = STATUS_FOUND;
                            state_next      = S_RESP;
                        end
                        else if (lk_miss)
                        begin
                            state_next = S_CREATE_INIT;
                        end
                    end
                    else
                    begin
                        if (!busy_q)
                        begin
                            res_slot_next   = SLOT_W'(cur_reg);
                            res_status_next = STATUS_CREATED;
                            state_next      = S_RESP;
                        end
                        else if (next_slot(cur_reg) == start_reg)
                        begin
                            res_slot_next   = '0;
                            res_status_next = STATUS_FULL;
                            state_next      = S_RESP;
                        end
                    end
                end
            end
            S_CREATE_INIT:
            begin
                probe_next      = start_reg;
                pend_next       = 1'b0;
                issued_all_next = 1'b0;
                state_next      = S_CREATE;
            end
            S_BUSY_RD:
            begin
                res_slot_next   = sidx_reg;
                res_status_next = STATUS_BUSY_SET;
                if (sidx_in_range)
                begin
                    state_next = S_BUSY_WR;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_BUSY_WR:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (load_out)
                begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = res_slot_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            key_reg        <= '0;
            sidx_reg       <= '0;
            bflag_reg      <= 1'b0;
            prod_reg       <= '0;
            start_reg      <= '0;
            probe_reg      <= '0;
            cur_reg        <= '0;
            pend_reg       <= 1'b0;
            first_reg      <= 1'b0;
            issued_all_reg <= 1'b0;
            res_slot_reg   <= '0;
            res_status_reg <= STATUS_FOUND;
            out_valid_reg  <= 1'b0;
            out_slot_reg   <= '0;
            out_status_reg <= STATUS_FOUND;
        end
        else
        begin
            state_reg      <= state_next;
            key_reg        <= key_next;
            sidx_reg       <= sidx_next;
            bflag_reg      <= bflag_next;
            prod_reg       <= prod_next;
            start_reg      <= start_next;
            probe_reg      <= probe_next;
            cur_reg        <= cur_next;
            pend_reg       <= pend_next;
            first_reg      <= first_next;
            issued_all_reg <= issued_all_next;
            res_slot_reg   <= res_slot_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_slot_reg   <= out_slot_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule

// ===== hdl/hmgoc_checker.sv =====
`include "hash_map_get_or_create_linear_probe_defines.svh"

module hmgoc_checker
    import hmgoc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [SLOT_W-1:0] rsp_result_slot,
    input logic [1:0]        rsp_status
);

    // Once a request is taken the block works on it alone.
    `HMGOC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

    // No request is answered in the cycle right after it is taken.
    `HMGOC_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready, !$rose(rsp_valid), "response too early")

    // A stalled response keeps its payload.
    `HMGOC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_slot) && $stable(rsp_status), "stalled response changed")

    // A full table reports slot zero.
    `HMGOC_ASSERT_SAME(a_full_slot_zero, rsp_valid && (rsp_status == STATUS_FULL), rsp_result_slot == '0, "full with nonzero slot")

endmodule

bind hash_map_get_or_create_linear_probe hmgoc_checker u_hmgoc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_result_slot (rsp.result_slot),
    .rsp_status      (rsp.status)
);
